// ----- src/spq_pkg.sv -----
`default_nettype none

package spq_pkg;

  localparam int unsigned CAPACITY_DEF = 128;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] PRIO_LOW  = 2'd1;
  localparam logic [1:0] PRIO_HIGH = 2'd3;

  localparam int unsigned NUM_CLASSES = 3;

  typedef struct packed {
    logic        action;
    logic [1:0]  priority_req;
    logic [15:0] tag;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] served_tag;
    logic [1:0]  served_priority;
    logic [7:0]  count;
  } out_t;

  typedef struct packed {
    logic load;
    logic do_write;
    logic do_read;
    logic post_err;
    logic post_ins;
    logic post_serve;
  } cmd_t;

  typedef struct packed {
    logic is_serve;
    logic full;
    logic empty;
  } stat_t;

endpackage

`default_nettype wire

// ----- src/spq_ctl.sv -----
`default_nettype none

module spq_ctl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  spq_pkg::stat_t      stat,
  output spq_pkg::cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_READ = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!stat.is_serve) begin
          if (stat.full) begin
            cmd.post_err = 1'b1;
          end else begin
            cmd.do_write = 1'b1;
            cmd.post_ins = 1'b1;
          end
          state_nxt = S_IDLE;
        end else if (stat.empty) begin
          cmd.post_err = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.do_read = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        cmd.post_serve = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  a_serve_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.post_serve |-> $past(cmd.do_read))
    else $error("serve result without a preceding memory read");

  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (cmd.post_err || cmd.post_ins || cmd.do_read))
    else $error("accepted word did not reach a decision");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("controller state is not one-hot");

endmodule

`default_nettype wire

// ----- src/spq_dp.sv -----
`default_nettype none

module spq_dp #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  spq_pkg::in_t        in_word,
  input  spq_pkg::cmd_t       cmd,
  output spq_pkg::stat_t      stat,
  output logic                out_strobe,
  output spq_pkg::out_t       out_word
);

  localparam int unsigned PW        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW        = $clog2(CAPACITY + 1);
  localparam int unsigned AW        = PW + 2;
  localparam int unsigned MEM_DEPTH = spq_pkg::NUM_CLASSES * (2 ** PW);

  logic [15:0]   mem_r [0:MEM_DEPTH-1];

  logic          act_r;
  logic [1:0]    cls_r;
  logic [15:0]   tag_r;

  logic [PW-1:0] head_r   [0:2];
  logic [PW-1:0] tail_r   [0:2];
  logic [CW-1:0] cnt_r    [0:2];
  logic [PW-1:0] head_nxt [0:2];
  logic [PW-1:0] tail_nxt [0:2];
  logic [CW-1:0] cnt_nxt  [0:2];
  logic [CW-1:0] total_r;
  logic [CW-1:0] total_nxt;

  logic [15:0]   rd_tag_r;
  logic [1:0]    rd_cls_r;

  logic          out_valid_r;
  spq_pkg::out_t out_r;
  spq_pkg::out_t out_nxt;

  logic [1:0]    in_cls;
  logic [1:0]    srv_cls;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(CAPACITY - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  assign in_cls = (in_word.priority_req == 2'd0) ? 2'd0 : 2'(in_word.priority_req - 2'd1);

  assign srv_cls = (cnt_r[2] != '0) ? 2'd2 : ((cnt_r[1] != '0) ? 2'd1 : 2'd0);

  assign waddr = {cls_r, tail_r[cls_r]};
  assign raddr = {srv_cls, head_r[srv_cls]};

  assign stat.is_serve = act_r;
  assign stat.full     = (total_r == CW'(CAPACITY));
  assign stat.empty    = (total_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_word.action;
      cls_r <= in_cls;
      tag_r <= in_word.tag;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      head_nxt[k] = head_r[k];
      tail_nxt[k] = tail_r[k];
      cnt_nxt[k]  = cnt_r[k];
    end
    total_nxt = total_r;
    if (cmd.do_write) begin
      tail_nxt[cls_r] = ptr_inc(tail_r[cls_r]);
      cnt_nxt[cls_r]  = CW'(cnt_r[cls_r] + 1'b1);
      total_nxt       = CW'(total_r + 1'b1);
    end else if (cmd.do_read) begin
      head_nxt[srv_cls] = ptr_inc(head_r[srv_cls]);
      cnt_nxt[srv_cls]  = CW'(cnt_r[srv_cls] - 1'b1);
      total_nxt         = CW'(total_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        head_r[k] <= '0;
        tail_r[k] <= '0;
        cnt_r[k]  <= '0;
      end
      total_r <= '0;
    end else begin
      for (int k = 0; k < 3; k++) begin
        head_r[k] <= head_nxt[k];
        tail_r[k] <= tail_nxt[k];
        cnt_r[k]  <= cnt_nxt[k];
      end
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_write) begin
      mem_r[waddr] <= tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_read) begin
      rd_tag_r <= mem_r[raddr];
      rd_cls_r <= srv_cls;
    end
  end

  always_comb begin
    out_nxt                 = '0;
    out_nxt.count           = 8'(total_nxt);
    if (cmd.post_serve) begin
      out_nxt.status          = spq_pkg::ST_OK;
      out_nxt.served_tag      = rd_tag_r;
      out_nxt.served_priority = 2'(rd_cls_r + 2'd1);
    end else if (cmd.post_err) begin
      out_nxt.status = act_r ? spq_pkg::ST_EMPTY : spq_pkg::ST_FULL;
    end else begin
      out_nxt.status = spq_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.post_err || cmd.post_ins || cmd.post_serve;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post_err || cmd.post_ins || cmd.post_serve) begin
      out_r <= out_nxt;
    end
  end

  assign out_strobe = out_valid_r;
  assign out_word   = out_r;

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_total_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (CW+2)'(total_r) == (CW+2)'(cnt_r[0]) + (CW+2)'(cnt_r[1]) + (CW+2)'(cnt_r[2]))
    else $error("class counts disagree with total count");

  a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != spq_pkg::ST_OK)
      |-> (out_r.served_tag == '0 && out_r.served_priority == '0))
    else $error("failed word carries served data");

  a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_read |-> (cnt_r[srv_cls] != '0))
    else $error("read from an empty class");

endmodule

`default_nettype wire

// ----- src/stable_priority_queue.sv -----
// Stable priority queue with room for CAPACITY tagged entries.
// Entries are served highest priority first (3 before 2 before 1), and
// entries of equal priority leave in the order they arrived. A requested
// priority of zero is treated as priority 1.
// Input channel: in_word is taken at a rising edge where start is high and
// busy is low. Action 0 inserts the entry, action 1 serves the head entry.
// Result channel: every accepted word yields exactly one result word on
// out_word, present for the single cycle in which out_strobe is high. The
// receiver cannot stall, so the result must be taken in that cycle.
// An insert or a failed serve registers its result from the decision in
// the execute state; a successful serve first passes through the registered
// read of the entry memory and the read state. busy drops as the result
// appears, so no new word is accepted before the last word's result is out.
// The entries live in one memory split into three circular regions, one for
// each priority level, each with its own head, tail and count.
// Reset (synchronous, rst_n low) empties the queue and clears any pending
// result; the memory contents are not cleared and need no clearing pass.
`default_nettype none

module stable_priority_queue #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  spq_pkg::in_t   in_word,
  output logic           out_strobe,
  output spq_pkg::out_t  out_word
);

  spq_pkg::cmd_t  cmd;
  spq_pkg::stat_t stat;

  spq_ctl u_ctl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  spq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule

`default_nettype wire
